### src/pse_pkg.sv
// pse_pkg: shared types, widths and reset values for the particle step integrator.
// Used by every module under src; depends on nothing.
package pse_pkg;

    localparam int MAX_PARTICLES_DEF = 4096;

    localparam int POS_W  = 24;  // signed Q15.8
    localparam int TIME_W = 24;  // signed Q7.16
    localparam int STEP_W = 17;  // unsigned Q1.16
    localparam int DIM_W  = 23;  // unsigned Q15.8

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP   = 3'd0,
        CFG_CULL_LEFT   = 3'd1,
        CFG_CULL_TOP    = 3'd2,
        CFG_CULL_WIDTH  = 3'd3,
        CFG_CULL_HEIGHT = 3'd4,
        CFG_CULL_MARGIN = 3'd5
    } t_cfg_idx;

    localparam logic [STEP_W-1:0] TIME_STEP_RST = 17'd1092;

    typedef struct packed {
        logic        [STEP_W-1:0] time_step;
        logic signed [POS_W-1:0]  cull_left;
        logic signed [POS_W-1:0]  cull_top;
        logic        [DIM_W-1:0]  cull_width;
        logic        [DIM_W-1:0]  cull_height;
        logic        [DIM_W-1:0]  cull_margin;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  vel_x;
        logic signed [POS_W-1:0]  vel_y;
        logic signed [TIME_W-1:0] life_rem;
        logic signed [TIME_W-1:0] spawn_phase;
        logic signed [TIME_W-1:0] user_timer;
    } t_particle;

    typedef struct packed {
        logic signed [POS_W-1:0]  new_pos_x;
        logic signed [POS_W-1:0]  new_pos_y;
        logic signed [TIME_W-1:0] new_life;
        logic signed [TIME_W-1:0] new_phase;
        logic signed [TIME_W-1:0] new_timer;
        logic                     dead;
    } t_update;

endpackage

### src/pse_cfg_regs.sv
// pse_cfg_regs: configuration register file, written one beat at a time.
// Depends on pse_pkg.
module pse_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [pse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pse_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pse_pkg::t_cfg                     o_cfg
);

    pse_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step   <= pse_pkg::TIME_STEP_RST;
            r_cfg.cull_left   <= '0;
            r_cfg.cull_top    <= '0;
            r_cfg.cull_width  <= '0;
            r_cfg.cull_height <= '0;
            r_cfg.cull_margin <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pse_pkg::CFG_TIME_STEP:   r_cfg.time_step   <= i_cfg_data[pse_pkg::STEP_W-1:0];
                pse_pkg::CFG_CULL_LEFT:   r_cfg.cull_left   <= i_cfg_data[pse_pkg::POS_W-1:0];
                pse_pkg::CFG_CULL_TOP:    r_cfg.cull_top    <= i_cfg_data[pse_pkg::POS_W-1:0];
                pse_pkg::CFG_CULL_WIDTH:  r_cfg.cull_width  <= i_cfg_data[pse_pkg::DIM_W-1:0];
                pse_pkg::CFG_CULL_HEIGHT: r_cfg.cull_height <= i_cfg_data[pse_pkg::DIM_W-1:0];
                pse_pkg::CFG_CULL_MARGIN: r_cfg.cull_margin <= i_cfg_data[pse_pkg::DIM_W-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/pse_advance.sv
// pse_advance: one axis of pos + vel * step, rounded to nearest and saturated.
// Depends on pse_pkg.
module pse_advance (
    input  logic signed [pse_pkg::POS_W-1:0]  i_pos,
    input  logic signed [pse_pkg::POS_W-1:0]  i_vel,
    input  logic        [pse_pkg::STEP_W-1:0] i_dt,
    output logic signed [pse_pkg::POS_W-1:0]  o_pos
);

    localparam int PROD_W = pse_pkg::POS_W + pse_pkg::STEP_W + 1;
    localparam int DISP_W = PROD_W - 16;
    localparam int SUM_W  = DISP_W + 1;

    logic signed [pse_pkg::STEP_W:0] dt_s;
    logic signed [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0]        rnd;
    logic signed [DISP_W-1:0]        disp;
    logic signed [SUM_W-1:0]         sum;

    always_comb begin
        dt_s = {1'b0, i_dt};
        prod = i_vel * dt_s;
        // Q.24 -> Q.8, half rounds up
        rnd  = prod + PROD_W'(32768);
        disp = rnd[PROD_W-1:16];
        sum  = {{(SUM_W-pse_pkg::POS_W){i_pos[pse_pkg::POS_W-1]}}, i_pos}
             + {disp[DISP_W-1], disp};
        if (!sum[SUM_W-1] && (sum[SUM_W-2:pse_pkg::POS_W-1] != '0)) begin
            o_pos = {1'b0, {(pse_pkg::POS_W-1){1'b1}}};
        end else if (sum[SUM_W-1] && (sum[SUM_W-2:pse_pkg::POS_W-1] != '1)) begin
            o_pos = {1'b1, {(pse_pkg::POS_W-1){1'b0}}};
        end else begin
            o_pos = sum[pse_pkg::POS_W-1:0];
        end
    end

endmodule

### src/pse_core.sv
// pse_core: single-pass update of one particle record (life, phase, motion, cull).
// Depends on pse_pkg and pse_advance.
module pse_core (
    input  pse_pkg::t_cfg      i_cfg,
    input  pse_pkg::t_particle i_p,
    output pse_pkg::t_update   o_u
);

    localparam int TW = pse_pkg::TIME_W;
    localparam int PW = pse_pkg::POS_W;
    localparam int EW = PW + 2;  // room for grown cull edges

    logic signed [TW:0]   dt_s;
    logic signed [TW:0]   life_sub;
    logic signed [TW:0]   phase_sub;
    logic signed [TW:0]   timer_sub;
    logic                 life_nonneg;
    logic                 life_expired;
    logic                 phase_pos;
    logic                 frozen;
    logic                 moving;
    logic                 cull_on;
    logic                 outside;
    logic signed [PW-1:0] adv_x;
    logic signed [PW-1:0] adv_y;
    logic signed [EW-1:0] px_e;
    logic signed [EW-1:0] py_e;
    logic signed [EW-1:0] x0;
    logic signed [EW-1:0] x1;
    logic signed [EW-1:0] y0;
    logic signed [EW-1:0] y1;

    pse_advance u_adv_x (
        .i_pos (i_p.pos_x),
        .i_vel (i_p.vel_x),
        .i_dt  (i_cfg.time_step),
        .o_pos (adv_x)
    );

    pse_advance u_adv_y (
        .i_pos (i_p.pos_y),
        .i_vel (i_p.vel_y),
        .i_dt  (i_cfg.time_step),
        .o_pos (adv_y)
    );

    always_comb begin
        dt_s      = {{(TW+1-pse_pkg::STEP_W){1'b0}}, i_cfg.time_step};
        life_sub  = {i_p.life_rem[TW-1], i_p.life_rem} - dt_s;
        phase_sub = {i_p.spawn_phase[TW-1], i_p.spawn_phase} - dt_s;
        timer_sub = {i_p.user_timer[TW-1], i_p.user_timer} - dt_s;

        life_nonneg  = !i_p.life_rem[TW-1];
        life_expired = life_nonneg && (life_sub[TW] || (life_sub == '0));
        phase_pos    = !i_p.spawn_phase[TW-1] && (i_p.spawn_phase != '0);
        frozen       = !life_expired && phase_pos && !phase_sub[TW] && (phase_sub != '0);
        moving       = !life_expired && !frozen;

        // grown rectangle, full width, edges inclusive
        px_e = {{(EW-PW){adv_x[PW-1]}}, adv_x};
        py_e = {{(EW-PW){adv_y[PW-1]}}, adv_y};
        x0   = {{(EW-PW){i_cfg.cull_left[PW-1]}}, i_cfg.cull_left}
             - {3'b000, i_cfg.cull_margin};
        y0   = {{(EW-PW){i_cfg.cull_top[PW-1]}}, i_cfg.cull_top}
             - {3'b000, i_cfg.cull_margin};
        x1   = {{(EW-PW){i_cfg.cull_left[PW-1]}}, i_cfg.cull_left}
             + {3'b000, i_cfg.cull_width} + {3'b000, i_cfg.cull_margin};
        y1   = {{(EW-PW){i_cfg.cull_top[PW-1]}}, i_cfg.cull_top}
             + {3'b000, i_cfg.cull_height} + {3'b000, i_cfg.cull_margin};
        cull_on = (i_cfg.cull_width != '0) && (i_cfg.cull_height != '0);
        outside = (px_e < x0) || (px_e > x1) || (py_e < y0) || (py_e > y1);

        o_u.new_life = life_nonneg ? life_sub[TW-1:0] : i_p.life_rem;

        if (!life_expired && phase_pos) begin
            o_u.new_phase = frozen ? phase_sub[TW-1:0] : '0;
        end else begin
            o_u.new_phase = i_p.spawn_phase;
        end

        o_u.new_pos_x = moving ? adv_x : i_p.pos_x;
        o_u.new_pos_y = moving ? adv_y : i_p.pos_y;

        if (moving && !i_p.user_timer[TW-1] && (i_p.user_timer != '0)) begin
            o_u.new_timer = timer_sub[TW-1:0];
        end else begin
            o_u.new_timer = i_p.user_timer;
        end

        o_u.dead = life_expired || (moving && cull_on && outside);
    end

endmodule

### src/particle_step_integrator.sv
// particle_step_integrator: top level; input register, update logic, result register.
// Depends on pse_pkg, pse_cfg_regs and pse_core.
//
// Usage:
//   Input channel: one particle record per beat on i_valid / o_stall. A beat
//   is taken at a rising edge with i_valid high and o_stall low.
//   Output channel: one updated record per input beat on o_valid / i_stall,
//   in arrival order; slot and the last flag are carried through untouched.
//   Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//   selects the register, i_cfg_data carries the value. Write only while the
//   pipe is empty; unmapped indices are dropped.
//   A taken beat is offered on the output once it reaches the result register.
//   Throughput: one particle per cycle while i_stall is low; the whole update
//   (two 24x17 multiplies, rounding, saturation and cull compares) sits
//   between the input register and the result register.
//   Reset (synchronous, active low): both stages empty, config back to a
//   step of 1092 and culling off.
//   Stall: a held result keeps the output register; the input register
//   still takes a beat while it is empty, so o_stall only rises once both
//   stages are full and i_stall is high.
module particle_step_integrator #(
    parameter int MAX_PARTICLES = pse_pkg::MAX_PARTICLES_DEF,
    localparam int SLOT_W       = $clog2(MAX_PARTICLES)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pse_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pse_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [SLOT_W-1:0]                    i_slot,
    input  logic signed [pse_pkg::POS_W-1:0]     i_pos_x,
    input  logic signed [pse_pkg::POS_W-1:0]     i_pos_y,
    input  logic signed [pse_pkg::POS_W-1:0]     i_vel_x,
    input  logic signed [pse_pkg::POS_W-1:0]     i_vel_y,
    input  logic signed [pse_pkg::TIME_W-1:0]    i_life_rem,
    input  logic signed [pse_pkg::TIME_W-1:0]    i_spawn_phase,
    input  logic signed [pse_pkg::TIME_W-1:0]    i_user_timer,
    input  logic                                 i_last_in,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [SLOT_W-1:0]                    o_slot_out,
    output logic signed [pse_pkg::POS_W-1:0]     o_new_pos_x,
    output logic signed [pse_pkg::POS_W-1:0]     o_new_pos_y,
    output logic signed [pse_pkg::TIME_W-1:0]    o_new_life,
    output logic signed [pse_pkg::TIME_W-1:0]    o_new_phase,
    output logic signed [pse_pkg::TIME_W-1:0]    o_new_timer,
    output logic                                 o_dead,
    output logic                                 o_last_out
);

    pse_pkg::t_cfg      cfg;
    pse_pkg::t_particle in_rec;
    pse_pkg::t_update   upd;

    // input stage
    logic               r_in_valid;
    pse_pkg::t_particle r_in_rec;
    logic [SLOT_W-1:0]  r_in_slot;
    logic               r_in_last;

    // result stage
    logic               r_out_valid;
    pse_pkg::t_update   r_out_upd;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_last;

    logic               out_en;
    logic               in_en;

    assign o_cfg_ready = 1'b1;

    pse_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    always_comb begin
        in_rec.pos_x       = i_pos_x;
        in_rec.pos_y       = i_pos_y;
        in_rec.vel_x       = i_vel_x;
        in_rec.vel_y       = i_vel_y;
        in_rec.life_rem    = i_life_rem;
        in_rec.spawn_phase = i_spawn_phase;
        in_rec.user_timer  = i_user_timer;
    end

    // each stage moves when the one after it has room
    assign out_en  = !r_out_valid || !i_stall;
    assign in_en   = !r_in_valid || out_en;
    assign o_stall = !in_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en && i_valid) begin
            r_in_rec  <= in_rec;
            r_in_slot <= i_slot;
            r_in_last <= i_last_in;
        end
    end

    pse_core u_core (
        .i_cfg (cfg),
        .i_p   (r_in_rec),
        .o_u   (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_in_valid) begin
            r_out_upd  <= upd;
            r_out_slot <= r_in_slot;
            r_out_last <= r_in_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_slot_out  = r_out_slot;
    assign o_new_pos_x = r_out_upd.new_pos_x;
    assign o_new_pos_y = r_out_upd.new_pos_y;
    assign o_new_life  = r_out_upd.new_life;
    assign o_new_phase = r_out_upd.new_phase;
    assign o_new_timer = r_out_upd.new_timer;
    assign o_dead      = r_out_upd.dead;
    assign o_last_out  = r_out_last;

endmodule

### tb/sv/particle_step_integrator_tb.sv
`timescale 1ns / 100ps
// particle_step_integrator_tb: self-checking bench for the particle step integrator.
// Holds its own Euler-step predictor in a small scoreboard class; needs pse_pkg and the block.
module particle_step_integrator_tb;
    import pse_pkg::*;

    localparam int SLOT_W     = $clog2(MAX_PARTICLES_DEF);
    localparam int SLOT_MAX   = MAX_PARTICLES_DEF - 1;
    localparam int IDLE_LIMIT = 1000;   // far above the worst gap + stall + latency
    localparam int IDLE_MAX   = 17;
    localparam int PHASE_CNT  = 8;
    localparam int PHASE_BEATS = 138;   // about 1100 random beats in all

    // one beat on the input channel and one on the output channel
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_particle         rec;
        logic              last;
    } t_particle_beat;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_update           upd;
        logic              last;
    } t_update_beat;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the registers, predicted updates in order.
    // ------------------------------------------------------------------
    class integrator_scoreboard;
        t_cfg         regs;
        t_update_beat expected_updates[$];
        int unsigned  n_checked;
        int unsigned  n_errors;
        int unsigned  n_dead;
        int unsigned  n_frozen;
        int unsigned  n_saturated;

        function new();
            regs.time_step   = TIME_STEP_RST;
            regs.cull_left   = '0;
            regs.cull_top    = '0;
            regs.cull_width  = '0;
            regs.cull_height = '0;
            regs.cull_margin = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TIME_STEP:   regs.time_step   = data[STEP_W-1:0];
                CFG_CULL_LEFT:   regs.cull_left   = data;
                CFG_CULL_TOP:    regs.cull_top    = data;
                CFG_CULL_WIDTH:  regs.cull_width  = data[DIM_W-1:0];
                CFG_CULL_HEIGHT: regs.cull_height = data[DIM_W-1:0];
                CFG_CULL_MARGIN: regs.cull_margin = data[DIM_W-1:0];
                default: ;      // unmapped index: dropped
            endcase
        endfunction

        // pos + vel*dt, product rounded half up to Q.8, then clamped to 24 bits
        function logic signed [POS_W-1:0] move_axis(logic signed [POS_W-1:0] pos,
                                                    logic signed [POS_W-1:0] vel,
                                                    logic [STEP_W-1:0] dt);
            longint prod;
            longint sum;
            prod = longint'(vel) * longint'(dt);
            sum  = longint'(pos) + ((prod + 64'sd32768) >>> 16);
            if (sum > longint'(24'sh7FFFFF) || sum < -longint'(32'sd8388608)) begin
                n_saturated++;
                return (sum > 0) ? 24'sh7FFFFF : 24'sh800000;
            end
            return POS_W'(sum);
        endfunction

        function t_update_beat predict_update(t_particle_beat b);
            t_update_beat u;
            int           dt;
            int           life;
            int           phase;
            int           timer;
            logic signed [POS_W-1:0] px;
            logic signed [POS_W-1:0] py;
            longint       x0;
            longint       y0;
            longint       x1;
            longint       y1;
            bit           dead;
            bit           moving;
            dt     = int'(regs.time_step);
            life   = $signed(b.rec.life_rem);
            phase  = $signed(b.rec.spawn_phase);
            timer  = $signed(b.rec.user_timer);
            px     = b.rec.pos_x;
            py     = b.rec.pos_y;
            dead   = 1'b0;
            moving = 1'b1;
            // negative life = immortal
            if (life >= 0) begin
                life -= dt;
                if (life <= 0) begin
                    dead   = 1'b1;
                    moving = 1'b0;
                end
            end
            // spawn freeze: still positive after the step -> nothing else moves
            if (moving && phase > 0) begin
                phase -= dt;
                if (phase > 0) begin
                    moving = 1'b0;
                    n_frozen++;
                end else begin
                    phase = 0;
                end
            end
            if (moving) begin
                px = move_axis(px, b.rec.vel_x, regs.time_step);
                py = move_axis(py, b.rec.vel_y, regs.time_step);
                if (timer > 0) begin
                    timer -= dt;
                end
                // grown rectangle at full width; edges count as inside
                if (regs.cull_width != '0 && regs.cull_height != '0) begin
                    x0 = longint'($signed(regs.cull_left)) - longint'(regs.cull_margin);
                    y0 = longint'($signed(regs.cull_top)) - longint'(regs.cull_margin);
                    x1 = longint'($signed(regs.cull_left)) + longint'(regs.cull_width)
                         + longint'(regs.cull_margin);
                    y1 = longint'($signed(regs.cull_top)) + longint'(regs.cull_height)
                         + longint'(regs.cull_margin);
                    if (longint'(px) < x0 || longint'(px) > x1 ||
                        longint'(py) < y0 || longint'(py) > y1) begin
                        dead = 1'b1;
                    end
                end
            end
            if (dead) begin
                n_dead++;
            end
            u.slot          = b.slot;
            u.upd.new_pos_x = px;
            u.upd.new_pos_y = py;
            u.upd.new_life  = TIME_W'(life);
            u.upd.new_phase = TIME_W'(phase);
            u.upd.new_timer = TIME_W'(timer);
            u.upd.dead      = dead;
            u.last          = b.last;
            return u;
        endfunction

        function void note_particle(t_particle_beat b);
            expected_updates.insert(expected_updates.size(), predict_update(b));
        endfunction

        function int pending();
            return expected_updates.size();
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            n_errors++;
        endtask

        task compare(string name, logic [23:0] got, logic [23:0] want, int slot);
            if (got !== want) begin
                report($sformatf("slot %0d %s got %h want %h", slot, name, got, want));
            end
        endtask

        task check_update(t_update_beat got);
            t_update_beat want;
            if (expected_updates.size() == 0) begin
                report($sformatf("result beat for slot %0d with nothing outstanding", got.slot));
                return;
            end
            want = expected_updates.pop_front();
            n_checked++;
            compare("slot",    24'(got.slot),          24'(want.slot),          want.slot);
            compare("pos_x",   got.upd.new_pos_x,      want.upd.new_pos_x,      want.slot);
            compare("pos_y",   got.upd.new_pos_y,      want.upd.new_pos_y,      want.slot);
            compare("life",    got.upd.new_life,       want.upd.new_life,       want.slot);
            compare("phase",   got.upd.new_phase,      want.upd.new_phase,      want.slot);
            compare("timer",   got.upd.new_timer,      want.upd.new_timer,      want.slot);
            compare("dead",    24'(got.upd.dead),      24'(want.upd.dead),      want.slot);
            compare("last",    24'(got.last),          24'(want.last),          want.slot);
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic [SLOT_W-1:0]        i_slot;
    logic signed [POS_W-1:0]  i_pos_x;
    logic signed [POS_W-1:0]  i_pos_y;
    logic signed [POS_W-1:0]  i_vel_x;
    logic signed [POS_W-1:0]  i_vel_y;
    logic signed [TIME_W-1:0] i_life_rem;
    logic signed [TIME_W-1:0] i_spawn_phase;
    logic signed [TIME_W-1:0] i_user_timer;
    logic                     i_last_in;
    logic                     o_valid;
    logic                     i_stall;
    logic [SLOT_W-1:0]        o_slot_out;
    logic signed [POS_W-1:0]  o_new_pos_x;
    logic signed [POS_W-1:0]  o_new_pos_y;
    logic signed [TIME_W-1:0] o_new_life;
    logic signed [TIME_W-1:0] o_new_phase;
    logic signed [TIME_W-1:0] o_new_timer;
    logic                     o_dead;
    logic                     o_last_out;

    particle_step_integrator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_slot        (i_slot),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_life_rem    (i_life_rem),
        .i_spawn_phase (i_spawn_phase),
        .i_user_timer  (i_user_timer),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_slot_out    (o_slot_out),
        .o_new_pos_x   (o_new_pos_x),
        .o_new_pos_y   (o_new_pos_y),
        .o_new_life    (o_new_life),
        .o_new_phase   (o_new_phase),
        .o_new_timer   (o_new_timer),
        .o_dead        (o_dead),
        .o_last_out    (o_last_out)
    );

    integrator_scoreboard sb;
    t_cfg        cur_cfg;       // setting in force, used to aim the stimulus
    int          n_settings;
    int          in_calm;       // beats left in a no-gap stretch, sender side
    int          out_calm;      // same for the receiver
    int          batch_left;
    int          batch_slot;
    int          quiet_cycles;

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: counts edges with no beat on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                     quiet_cycles, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Gap or stall length per beat, up to IDLE_MAX, with occasional stretches of none.
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 60);
        end
        return $urandom_range(0, IDLE_MAX);
    endfunction

    // Coordinate, aimed at the edges of the grown cull rectangle four times in ten.
    function automatic logic signed [POS_W-1:0] pick_coord(longint lo, longint hi);
        case ($urandom_range(0, 9))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2, 3:    return POS_W'($urandom);
            4, 5:    return POS_W'(lo + longint'($urandom_range(0, 600)) - 300);
            6, 7:    return POS_W'(hi + longint'($urandom_range(0, 600)) - 300);
            default: return POS_W'(lo + longint'($urandom) % (hi - lo + 1));
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_vel();
        case ($urandom_range(0, 7))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return '0;
            3, 4:    return POS_W'($urandom);
            default: return POS_W'(int'($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    // Time value: p_big % above the step, p_low % not positive, 20 % near the
    // step (expiry boundary), the rest extremes and full-range noise.
    function automatic logic signed [TIME_W-1:0] pick_time(int dt, int p_big, int p_low);
        int r;
        r = $urandom_range(0, 99);
        if (r < p_big) begin
            return TIME_W'($urandom_range(dt + 1, 8388607));
        end
        if (r < p_big + p_low) begin
            return TIME_W'(-int'($urandom_range(0, 8388608)));
        end
        if (r < p_big + p_low + 20) begin
            return TIME_W'(dt + int'($urandom_range(0, 4)) - 2);
        end
        case ($urandom_range(0, 3))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return '0;
            default: return TIME_W'($urandom);
        endcase
    endfunction

    // Batches run from a top slot down, last flag on the final one;
    // about one beat in ten is a stray slot with a random flag.
    function automatic t_particle_beat random_particle();
        t_particle_beat b;
        longint         lo_x;
        longint         hi_x;
        longint         lo_y;
        longint         hi_y;
        int             dt;
        dt   = int'(cur_cfg.time_step);
        lo_x = longint'($signed(cur_cfg.cull_left)) - longint'(cur_cfg.cull_margin);
        hi_x = longint'($signed(cur_cfg.cull_left)) + longint'(cur_cfg.cull_width)
               + longint'(cur_cfg.cull_margin);
        lo_y = longint'($signed(cur_cfg.cull_top)) - longint'(cur_cfg.cull_margin);
        hi_y = longint'($signed(cur_cfg.cull_top)) + longint'(cur_cfg.cull_height)
               + longint'(cur_cfg.cull_margin);
        if ($urandom_range(0, 9) == 0) begin
            b.slot = SLOT_W'($urandom_range(0, SLOT_MAX));
            b.last = 1'($urandom);
        end else begin
            if (batch_left == 0) begin
                batch_left = $urandom_range(1, 40);
                batch_slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SLOT_MAX)
                                                         : batch_left - 1;
            end
            b.slot = SLOT_W'(batch_slot);
            batch_left--;
            b.last = (batch_left == 0 || batch_slot == 0);
            if (b.last) begin
                batch_left = 0;
            end
            batch_slot--;
        end
        b.rec.pos_x       = pick_coord(lo_x, hi_x);
        b.rec.pos_y       = pick_coord(lo_y, hi_y);
        b.rec.vel_x       = pick_vel();
        b.rec.vel_y       = pick_vel();
        b.rec.life_rem    = pick_time(dt, 35, 25);
        b.rec.spawn_phase = pick_time(dt, 15, 50);
        b.rec.user_timer  = pick_time(dt, 40, 20);
        return b;
    endfunction

    function automatic t_cfg make_cfg(logic [STEP_W-1:0] dt, logic signed [POS_W-1:0] left,
                                      logic signed [POS_W-1:0] top, logic [DIM_W-1:0] w,
                                      logic [DIM_W-1:0] h, logic [DIM_W-1:0] m);
        t_cfg c;
        c.time_step   = dt;
        c.cull_left   = left;
        c.cull_top    = top;
        c.cull_width  = w;
        c.cull_height = h;
        c.cull_margin = m;
        return c;
    endfunction

    // Settings for the random phases: extremes first, then random regions.
    function automatic t_cfg pick_cfg(int flavour);
        t_cfg c;
        c = make_cfg(STEP_W'($urandom_range(0, 131071)),
                     POS_W'(int'($urandom_range(0, 40000)) - 20000),
                     POS_W'(int'($urandom_range(0, 40000)) - 20000),
                     DIM_W'($urandom_range(0, 30000)), DIM_W'($urandom_range(0, 30000)),
                     DIM_W'($urandom_range(0, 3000)));
        case (flavour)
            0: c = make_cfg(17'd65536, 24'sh800000, 24'sh7FFFFF,
                            23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
            1: c.time_step = '0;
            2: begin
                c.time_step   = 17'h1FFFF;
                c.cull_margin = '0;
            end
            3: begin
                c.time_step  = TIME_STEP_RST;
                c.cull_width = '0;          // culling off
            end
            4: c.cull_height = '0;
            5: begin
                c.cull_left = 24'sh7FFFFF;
                c.cull_top  = 24'sh800000;
            end
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    // Writes every index, spare ones too; valid stays up across the burst.
    task automatic program_regs(input t_cfg c);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        for (int k = 0; k < (1 << CFG_IDX_W); k++) begin
            idx = CFG_IDX_W'(k);
            case (idx)
                CFG_TIME_STEP:   data = {7'($urandom), c.time_step};
                CFG_CULL_LEFT:   data = c.cull_left;
                CFG_CULL_TOP:    data = c.cull_top;
                CFG_CULL_WIDTH:  data = {1'($urandom), c.cull_width};
                CFG_CULL_HEIGHT: data = {1'($urandom), c.cull_height};
                CFG_CULL_MARGIN: data = {1'($urandom), c.cull_margin};
                default:         data = CFG_DATA_W'($urandom);
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            sb.write_reg(idx, data);
        end
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
        n_settings++;
    endtask

    // Valid is left high on return so a back-to-back beat needs no toggle.
    task automatic send_particle(input t_particle_beat b);
        int gap;
        gap = draw_idle(in_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_slot        <= b.slot;
        i_pos_x       <= b.rec.pos_x;
        i_pos_y       <= b.rec.pos_y;
        i_vel_x       <= b.rec.vel_x;
        i_vel_y       <= b.rec.vel_y;
        i_life_rem    <= b.rec.life_rem;
        i_spawn_phase <= b.rec.spawn_phase;
        i_user_timer  <= b.rec.user_timer;
        i_last_in     <= b.last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_particle(b);
    endtask

    task automatic send_fields(input int slot, input logic signed [POS_W-1:0] px,
                               input logic signed [POS_W-1:0] py,
                               input logic signed [POS_W-1:0] vx,
                               input logic signed [POS_W-1:0] vy,
                               input logic signed [TIME_W-1:0] life,
                               input logic signed [TIME_W-1:0] phase,
                               input logic signed [TIME_W-1:0] timer, input logic last);
        t_particle_beat b;
        b.slot            = SLOT_W'(slot);
        b.rec.pos_x       = px;
        b.rec.pos_y       = py;
        b.rec.vel_x       = vx;
        b.rec.vel_y       = vy;
        b.rec.life_rem    = life;
        b.rec.spawn_phase = phase;
        b.rec.user_timer  = timer;
        b.last            = last;
        send_particle(b);
    endtask

    // Input side quiet, every outstanding result back: pipe is empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Result side: random stall per beat, sampled at the accepting edge.
    task automatic collect_updates();
        t_update_beat got;
        int           hold;
        forever begin
            hold = draw_idle(out_calm);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got.slot          = o_slot_out;
            got.upd.new_pos_x = o_new_pos_x;
            got.upd.new_pos_y = o_new_pos_y;
            got.upd.new_life  = o_new_life;
            got.upd.new_phase = o_new_phase;
            got.upd.new_timer = o_new_timer;
            got.upd.dead      = o_dead;
            got.last          = o_last_out;
            sb.check_update(got);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb           = new();
        cur_cfg      = sb.regs;
        n_settings   = 1;           // reset values count as the first setting
        in_calm      = 0;
        out_calm     = 0;
        batch_left   = 0;
        batch_slot   = 0;
        quiet_cycles = 0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_slot        <= '0;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_vel_x       <= '0;
        i_vel_y       <= '0;
        i_life_rem    <= '0;
        i_spawn_phase <= '0;
        i_user_timer  <= '0;
        i_last_in     <= 1'b0;
        i_stall       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            collect_updates();
        join_none

        // Reset setting: step 1092, no culling.
        send_fields(SLOT_MAX, 24'sh7FFFFF, 24'sh800000, 0, 0, 0, 0, 0, 1'b0);   // life zero
        send_fields(4094, 100, 100, 256, 256, 1092, 0, 5, 1'b0);        // life hits zero exactly
        send_fields(4093, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                    1093, 0, 0, 1'b0);                                  // clamps both ways
        send_fields(4092, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                    -1, 0, 0, 1'b0);                                    // immortal, clamps
        send_fields(2048, 0, 0, 1000, -1000, 24'sh7FFFFF, 1092, 1, 1'b0); // phase ends, timer < 0
        send_fields(1024, 0, 0, 1000, -1000, -1, 1093, 24'sh7FFFFF, 1'b0); // still frozen
        send_fields(1, 0, 0, 1, -1, 24'sh800000, 24'sh800000, 24'sh800000, 1'b0);
        send_fields(0, 1, 1, 60, 60, 24'sh7FFFFF, 0, 24'sh7FFFFF, 1'b1);

        // Half-second step, culling on: box x -2816..2816, y 2304..5376 once grown.
        drain();
        program_regs(make_cfg(17'd32768, -2560, 2560, 23'd5120, 23'd2560, 23'd256));
        send_fields(10, -2816, 2304, 0, 0, -1, 0, 0, 1'b0);   // on the corner: inside
        send_fields(9, -2817, 2304, 0, 0, -1, 0, 0, 1'b0);
        send_fields(8, 2816, 5376, 0, 0, -1, 0, 0, 1'b0);
        send_fields(7, 2817, 5376, 0, 0, -1, 0, 0, 1'b0);
        send_fields(6, 0, 2303, 0, 0, -1, 0, 0, 1'b0);
        send_fields(5, 0, 5377, 0, 0, -1, 0, 0, 1'b0);
        send_fields(4, 2800, 3000, 100, 0, -1, 0, 0, 1'b0);   // moves out of the box
        send_fields(3, 0, 3000, 1, -1, -1, 0, 0, 1'b0);       // rounding ties go up
        send_fields(2, 0, 3000, 3, -3, -1, 0, 0, 1'b0);
        send_fields(1, 24'sh7FFFFF, 24'sh800000, 0, 0, -1, 40000, 0, 1'b0); // frozen: no cull
        send_fields(0, 24'sh7FFFFF, 0, 0, 0, 100, 0, 0, 1'b1);  // expired: position kept

        // Largest step, culling off by a zero width.
        drain();
        program_regs(make_cfg(17'h1FFFF, 24'sh7FFFFF, 24'sh800000, 23'd0, 23'd5, 23'h7FFFFF));
        send_fields(3, 0, 0, 24'sh7FFFFF, 24'sh800000, -1, 0, 0, 1'b0);
        send_fields(2, 0, 0, 0, 0, 131071, 0, 0, 1'b0);
        send_fields(1, 0, 0, 0, 0, 131072, 131072, 131072, 1'b1);

        // Zero step into a one-unit box.
        drain();
        program_regs(make_cfg(17'd0, 0, 0, 23'd1, 23'd1, 23'd0));
        send_fields(1, 0, 0, 0, 0, 0, 1, 5, 1'b0);
        send_fields(0, 1, 1, 24'sh7FFFFF, 0, 5, 0, 5, 1'b1);

        // Random phases; each starts from an empty pipe with a fresh setting.
        for (int p = 0; p < PHASE_CNT; p++) begin
            drain();
            program_regs(pick_cfg(p));
            repeat (PHASE_BEATS) send_particle(random_particle());
        end

        drain();
        repeat (4) @(posedge i_clk);   // two-stage pipe: anything stray shows by now

        $display("Checked %0d particle updates across %0d register settings.",
                 sb.n_checked, n_settings);
        $display("Of those %0d died, %0d stayed frozen, %0d axis moves clamped; %0d errors.",
                 sb.n_dead, sb.n_frozen, sb.n_saturated, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
